### sv/tea_pkg.sv
`default_nettype none

package tea_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int ROUND_COUNT_DEFAULT = 32;
   localparam int SHIFT_LEFT = 4;
   localparam int SHIFT_RIGHT = 5;
   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ZERO = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ONE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_TWO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_THREE = 2'd3;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type first;
      word_type second;
   } block_type;

   typedef struct packed {
      word_type shl_key;
      word_type shr_key;
   } key_pair_type;

   // Running sum of the golden-ratio constant after a given number of rounds.
   function automatic word_type round_sum(input int rounds);
      logic [63:0] product;
      begin
         product = 64'(rounds) * 64'(TEA_DELTA);
         return product[WORD_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### sv/tea_req_if.sv
`default_nettype none

interface tea_req_if;
   logic valid;
   logic ready;
   logic [tea_pkg::WORD_WIDTH-1:0] plain_first;
   logic [tea_pkg::WORD_WIDTH-1:0] plain_second;

   modport source (output valid, output plain_first, output plain_second, input ready);
   modport sink (input valid, input plain_first, input plain_second, output ready);
endinterface

`default_nettype wire

### sv/tea_rsp_if.sv
`default_nettype none

interface tea_rsp_if;
   logic valid;
   logic ready;
   logic [tea_pkg::WORD_WIDTH-1:0] cipher_first;
   logic [tea_pkg::WORD_WIDTH-1:0] cipher_second;

   modport source (output valid, output cipher_first, output cipher_second, input ready);
   modport sink (input valid, input cipher_first, input cipher_second, output ready);
endinterface

`default_nettype wire

### sv/tea_cell.sv
`default_nettype none

// One half round of the cipher with its own output register. UPDATE_SECOND
// selects which half is updated; the other half only passes through.
module tea_cell #(
   parameter bit UPDATE_SECOND = 1'b0,
   parameter tea_pkg::word_type ROUND_SUM = tea_pkg::TEA_DELTA
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire tea_pkg::key_pair_type keys,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire tea_pkg::block_type    in_data,
   output logic                       out_valid,
   input  wire                        out_ready,
   output tea_pkg::block_type         out_data
);

   logic               valid_ff;
   logic               valid_in;
   tea_pkg::block_type data_ff;
   tea_pkg::block_type data_in;
   tea_pkg::word_type  mix_src;
   tea_pkg::word_type  mix;

   assign mix_src = UPDATE_SECOND ? in_data.first : in_data.second;

   assign mix = ((mix_src << tea_pkg::SHIFT_LEFT) + keys.shl_key)
              ^ (mix_src + ROUND_SUM)
              ^ ((mix_src >> tea_pkg::SHIFT_RIGHT) + keys.shr_key);

   always_comb begin
      data_in = in_data;
      if (UPDATE_SECOND) begin
         data_in.second = in_data.second + mix;
      end else begin
         data_in.first = in_data.first + mix;
      end
   end

   // The cell takes a new block whenever its register is empty or drains now.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

### sv/tea_block_encrypt.sv
`default_nettype none

// TEA block encryption engine. Each transfer on req carries one 64-bit
// plaintext block and produces exactly one ciphertext block on rsp, in order.
// The rounds are unrolled into a chain of 2*ROUND_COUNT half-round cells, one
// register each; a block passes through every cell register from req to rsp,
// and one block can enter every cycle as long as rsp is drained. Every cell
// holds its block while stalled, so a waiting result does not stop req until
// the whole chain is full. The 128-bit key is written through csr, one 32-bit
// word per index, and must only change while no block is in flight.
module tea_block_encrypt #(
   parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   tea_req_if.sink                                req,
   tea_rsp_if.source                              rsp,
   input  wire                                    csr_write_enable,
   input  wire  [tea_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire  [tea_pkg::WORD_WIDTH-1:0]         csr_write_data
);

   localparam int CellCount = 2 * ROUND_COUNT;

   tea_pkg::word_type key_word_zero_ff;
   tea_pkg::word_type key_word_one_ff;
   tea_pkg::word_type key_word_two_ff;
   tea_pkg::word_type key_word_three_ff;

   tea_pkg::key_pair_type first_keys;
   tea_pkg::key_pair_type second_keys;

   tea_pkg::block_type chain_data [CellCount+1];
   logic               chain_valid [CellCount+1];
   logic               chain_ready [CellCount+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_zero_ff <= '0;
         key_word_one_ff <= '0;
         key_word_two_ff <= '0;
         key_word_three_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tea_pkg::CSR_KEY_WORD_ZERO: key_word_zero_ff <= csr_write_data;
            tea_pkg::CSR_KEY_WORD_ONE: key_word_one_ff <= csr_write_data;
            tea_pkg::CSR_KEY_WORD_TWO: key_word_two_ff <= csr_write_data;
            tea_pkg::CSR_KEY_WORD_THREE: key_word_three_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign first_keys = '{shl_key: key_word_zero_ff, shr_key: key_word_one_ff};
   assign second_keys = '{shl_key: key_word_two_ff, shr_key: key_word_three_ff};

   assign chain_valid[0] = req.valid;
   assign chain_data[0] = '{first: req.plain_first, second: req.plain_second};
   assign req.ready = chain_ready[0];

   // Even cells update the first half, odd cells the second half of a round.
   for (genvar c = 0; c < CellCount; c++) begin : g_cell
      localparam tea_pkg::word_type RoundSum = tea_pkg::round_sum(c / 2 + 1);
      localparam bit UpdateSecond = (c % 2) == 1;

      tea_cell #(
         .UPDATE_SECOND (UpdateSecond),
         .ROUND_SUM     (RoundSum)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .keys      (UpdateSecond ? second_keys : first_keys),
         .in_valid  (chain_valid[c]),
         .in_ready  (chain_ready[c]),
         .in_data   (chain_data[c]),
         .out_valid (chain_valid[c+1]),
         .out_ready (chain_ready[c+1]),
         .out_data  (chain_data[c+1])
      );
   end

   assign chain_ready[CellCount] = rsp.ready;
   assign rsp.valid = chain_valid[CellCount];
   assign rsp.cipher_first = chain_data[CellCount].first;
   assign rsp.cipher_second = chain_data[CellCount].second;

   // The chain comes out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result valid right after reset");

   // The input only stalls when the first cell holds a block that cannot move.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (chain_valid[1] && !chain_ready[1]))
      else $error("input stalled with room in the first cell");

   // The last cell only fills from its neighbor, so the output is still idle in
   // the cycle after both of them were empty.
   assert property (@(posedge clock) disable iff (reset)
      (!chain_valid[CellCount] && !chain_valid[CellCount-1]) |=> !rsp.valid)
      else $error("result appeared without passing the last cell");

endmodule

`default_nettype wire
